### sv/reflectance_array_line_position_unit_defines.svh
// Assertion helpers shared by the RTL.
`ifndef REFLECTANCE_ARRAY_LINE_POSITION_UNIT_DEFINES_SVH
`define REFLECTANCE_ARRAY_LINE_POSITION_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rlp_pkg.sv
package rlp_pkg;

  localparam int PIN_W    = 8;
  localparam int THR_W    = 8;
  localparam int COUNT_W  = 8;
  localparam int MAP_W    = 8;
  localparam int OFFSET_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  localparam logic [THR_W-1:0] THR_LOW_RST  = 8'd96;
  localparam logic [THR_W-1:0] THR_HIGH_RST = 8'd104;

  localparam int OFFSET_MAX = 7;
  localparam int OFFSET_MIN = -8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 2'd1;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_WHITE   = 2'd1,
    CLS_BLACK   = 2'd2
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_MERGE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic tick;      // count this beat
    logic first;     // clear count before adding
    logic classify;  // latch new class
  } lane_ctl_t;

endpackage

### sv/rlp_lane.sv
module rlp_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlp_pkg::lane_ctl_t            ctl,
  input  logic                          pin,
  input  logic [rlp_pkg::THR_W-1:0]     thr_low,
  input  logic [rlp_pkg::THR_W-1:0]     thr_high,
  input  rlp_pkg::cls_t                 left_class,
  output rlp_pkg::cls_t                 new_class,
  output rlp_pkg::cls_t                 class_q
);

  logic [rlp_pkg::COUNT_W-1:0] count_r, count_nxt, count_base;
  rlp_pkg::cls_t               class_r, class_nxt;

  always_comb begin
    count_base = ctl.first ? '0 : count_r;
    count_nxt  = count_r;
    if (ctl.tick) begin
      count_nxt = count_base;
      if (pin && (count_base != rlp_pkg::COUNT_MAX)) begin
        count_nxt = count_base + rlp_pkg::COUNT_W'(1);
      end
    end
  end

  // hysteresis; inside the band an unknown sensor copies its left neighbor
  always_comb begin
    priority if (count_r < thr_low) begin
      new_class = rlp_pkg::CLS_WHITE;
    end else if (count_r > thr_high) begin
      new_class = rlp_pkg::CLS_BLACK;
    end else if ((class_r == rlp_pkg::CLS_WHITE) || (class_r == rlp_pkg::CLS_BLACK)) begin
      new_class = class_r;
    end else begin
      new_class = left_class;
    end
  end

  assign class_nxt = ctl.classify ? new_class : class_r;
  assign class_q   = class_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      class_r <= rlp_pkg::CLS_UNKNOWN;
    end else begin
      count_r <= count_nxt;
      class_r <= class_nxt;
    end
  end

endmodule

### sv/rlp_div.sv
module rlp_div #(
  parameter int DVD_W = 6,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    trial;
  logic              fits;
  logic [DVD_W:0]    quo_shift;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial     = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    fits      = (trial >= {1'b0, dvs_r});
    quo_shift = {quo_r, fits};
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      step_nxt = STEP_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (step_r != '0) begin
      step_nxt = step_r - STEP_W'(1);
      quo_nxt  = quo_shift[DVD_W-1:0];
      rem_nxt  = fits ? (trial - {1'b0, dvs_r}) : trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (step_r != '0);
  assign quotient = quo_r;

endmodule

### sv/reflectance_array_line_position_unit.sv
// Line position from an RC reflectance sensor array.
// Input channel (in_valid/in_ready): one beat per sampling tick, carrying the
// pin levels, a first flag that clears the high counts and a last flag that
// closes the window. Each sensor lane counts its high ticks, saturating at 255.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 threshold_low,
// index 1 threshold_high; other indexes are dropped.
// Output channel (out_valid/out_ready): one beat per last tick with the line
// offset, found/all-black/all-white flags and the black map.
// Ticks are accepted in the idle state. A last tick holds in_ready low through
// the classify, merge, divide and finish states; the divide state waits for the
// restoring dividers that average each half, which divide SUM_W-bit weight sums,
// SUM_W being the bit width of the larger half's weight sum (4 at 8 sensors).
// The finish state loads the result into the output register.
// A stalled receiver holds the output register; ticks keep flowing, and only
// the finish step of the next window waits for the register to free up.
// Reset (rst_n low, synchronous) clears counts, marks every sensor unknown,
// loads the thresholds with 96 and 104 and empties the output register.
`include "reflectance_array_line_position_unit_defines.svh"

module reflectance_array_line_position_unit #(
  parameter int SENSOR_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rlp_pkg::PIN_W-1:0]         in_pin_levels,
  input  logic                              in_first,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlp_pkg::THR_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rlp_pkg::OFFSET_W-1:0] out_line_offset,
  output logic                              out_line_found,
  output logic                              out_all_black,
  output logic                              out_all_white,
  output logic [rlp_pkg::MAP_W-1:0]         out_black_map
);

  localparam int HALF     = SENSOR_COUNT / 2;
  localparam int RN       = SENSOR_COUNT - HALF;
  localparam int LSUM_MAX = HALF * (HALF + 1) / 2;
  localparam int RSUM_MAX = RN * (RN + 1) / 2;
  localparam int SUM_MAX  = (LSUM_MAX > RSUM_MAX) ? LSUM_MAX : RSUM_MAX;
  localparam int SUM_W    = $clog2(SUM_MAX + 1);
  localparam int CNT_W    = $clog2(RN + 1);
  localparam int AVG_W    = CNT_W;
  localparam int DIFF_W   = AVG_W + 4;

  localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(rlp_pkg::OFFSET_MAX);
  localparam logic signed [DIFF_W-1:0] DIFF_LO = DIFF_W'(rlp_pkg::OFFSET_MIN);

  rlp_pkg::state_t state_r, state_nxt;

  logic [rlp_pkg::THR_W-1:0] thr_low_r, thr_high_r;

  logic in_acc, out_free;
  rlp_pkg::lane_ctl_t lane_ctl;

  rlp_pkg::cls_t cls_new [SENSOR_COUNT];
  rlp_pkg::cls_t cls_q   [SENSOR_COUNT];

  // merge
  logic [SUM_W-1:0] lsum, rsum;
  logic [CNT_W-1:0] lcnt, rcnt;
  logic             any_white, any_black;
  logic [rlp_pkg::MAP_W-1:0] map;
  logic [CNT_W-1:0] lcnt_r, rcnt_r;
  logic             any_white_r, any_black_r;
  logic [rlp_pkg::MAP_W-1:0] map_r;

  logic             div_start, ldiv_busy, rdiv_busy;
  logic [SUM_W-1:0] lquo, rquo;
  logic [AVG_W-1:0] lavg, ravg;
  logic signed [DIFF_W-1:0] diff, diff_sat;
  logic             found;

  logic             out_valid_r, out_valid_nxt, out_load;
  logic signed [rlp_pkg::OFFSET_W-1:0] offset_r;
  logic             found_r, all_black_r, all_white_r;
  logic [rlp_pkg::MAP_W-1:0] black_map_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r  <= rlp_pkg::THR_LOW_RST;
      thr_high_r <= rlp_pkg::THR_HIGH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == rlp_pkg::REG_THRESHOLD_LOW) begin
        thr_low_r <= cfg_data;
      end
      if (cfg_index == rlp_pkg::REG_THRESHOLD_HIGH) begin
        thr_high_r <= cfg_data;
      end
    end
  end

  // ---------------- sequencer ----------------
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlp_pkg::ST_IDLE: begin
        if (in_acc && in_last) begin
          state_nxt = rlp_pkg::ST_CLASSIFY;
        end
      end
      rlp_pkg::ST_CLASSIFY: state_nxt = rlp_pkg::ST_MERGE;
      rlp_pkg::ST_MERGE:    state_nxt = rlp_pkg::ST_DIVIDE;
      rlp_pkg::ST_DIVIDE: begin
        if (!ldiv_busy && !rdiv_busy) begin
          state_nxt = rlp_pkg::ST_FINISH;
        end
      end
      rlp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = rlp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rlp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    lane_ctl.tick     = 1'b0;
    lane_ctl.first    = in_first;
    lane_ctl.classify = 1'b0;
    div_start         = 1'b0;
    out_load          = 1'b0;
    unique case (state_r)
      rlp_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        lane_ctl.tick = in_acc;
      end
      rlp_pkg::ST_CLASSIFY: lane_ctl.classify = 1'b1;
      rlp_pkg::ST_MERGE:    div_start = 1'b1;
      rlp_pkg::ST_DIVIDE:   ;
      rlp_pkg::ST_FINISH:   out_load = out_free;
      default:              ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- sensor lanes ----------------
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    logic          pin;
    rlp_pkg::cls_t left_cls;

    if (g < rlp_pkg::PIN_W) begin : g_pin
      assign pin = in_pin_levels[g];
    end else begin : g_nopin
      assign pin = 1'b0;
    end

    if (g == 0) begin : g_edge
      assign left_cls = rlp_pkg::CLS_WHITE;
    end else begin : g_chain
      assign left_cls = cls_new[g-1];
    end

    rlp_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lane_ctl),
      .pin        (pin),
      .thr_low    (thr_low_r),
      .thr_high   (thr_high_r),
      .left_class (left_cls),
      .new_class  (cls_new[g]),
      .class_q    (cls_q[g])
    );
  end

  // ---------------- merge ----------------
  always_comb begin
    lsum      = '0;
    rsum      = '0;
    lcnt      = '0;
    rcnt      = '0;
    any_white = 1'b0;
    any_black = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (cls_q[i] == rlp_pkg::CLS_BLACK) begin
        any_black = 1'b1;
        if (i < HALF) begin
          lsum = lsum + SUM_W'(HALF - i);
          lcnt = lcnt + CNT_W'(1);
        end else begin
          rsum = rsum + SUM_W'(i - HALF + 1);
          rcnt = rcnt + CNT_W'(1);
        end
      end else if (cls_q[i] == rlp_pkg::CLS_WHITE) begin
        any_white = 1'b1;
      end
    end
  end

  for (genvar m = 0; m < rlp_pkg::MAP_W; m++) begin : g_map
    if (m < SENSOR_COUNT) begin : g_on
      assign map[m] = (cls_q[m] == rlp_pkg::CLS_BLACK);
    end else begin : g_off
      assign map[m] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      lcnt_r      <= lcnt;
      rcnt_r      <= rcnt;
      any_white_r <= any_white;
      any_black_r <= any_black;
      map_r       <= map;
    end
  end

  rlp_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_ldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lsum),
    .divisor  (lcnt),
    .busy     (ldiv_busy),
    .quotient (lquo)
  );

  rlp_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_rdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rsum),
    .divisor  (rcnt),
    .busy     (rdiv_busy),
    .quotient (rquo)
  );

  // empty half averages to zero
  assign lavg = (lcnt_r == '0) ? '0 : lquo[AVG_W-1:0];
  assign ravg = (rcnt_r == '0) ? '0 : rquo[AVG_W-1:0];

  always_comb begin
    diff = $signed({{(DIFF_W-AVG_W){1'b0}}, lavg}) - $signed({{(DIFF_W-AVG_W){1'b0}}, ravg});
    priority if (diff > DIFF_HI) begin
      diff_sat = DIFF_HI;
    end else if (diff < DIFF_LO) begin
      diff_sat = DIFF_LO;
    end else begin
      diff_sat = diff;
    end
  end

  assign found = !(((lcnt_r == CNT_W'(HALF)) && (rcnt_r == CNT_W'(RN)))
                   || ((lcnt_r == '0) && (rcnt_r == '0)));

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      offset_r    <= found ? diff_sat[rlp_pkg::OFFSET_W-1:0] : '0;
      found_r     <= found;
      all_black_r <= !any_white_r;
      all_white_r <= !any_black_r;
      black_map_r <= map_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_offset = offset_r;
  assign out_line_found  = found_r;
  assign out_all_black   = all_black_r;
  assign out_all_white   = all_white_r;
  assign out_black_map   = black_map_r;

  // ---------------- checks ----------------
  `RLP_ASSERT_NEXT(a_last_starts_classify, clk, rst_n, in_acc && in_last,
    state_r == rlp_pkg::ST_CLASSIFY, "last beat did not start classification")
  `RLP_ASSERT_NEXT(a_finish_loads_output, clk, rst_n,
    (state_r == rlp_pkg::ST_FINISH) && out_free,
    out_valid_r && (state_r == rlp_pkg::ST_IDLE), "finished result not loaded")
  `RLP_ASSERT_NOW(a_div_idle, clk, rst_n, state_r == rlp_pkg::ST_IDLE,
    !ldiv_busy && !rdiv_busy, "divider busy while idle")
  `RLP_ASSERT_NOW(a_flags_vs_found, clk, rst_n, out_valid_r && (out_all_black || out_all_white),
    !out_line_found, "line found with a uniform array")
  `RLP_ASSERT_NOW(a_lost_offset_zero, clk, rst_n, out_valid_r && !out_line_found,
    out_line_offset == '0, "nonzero offset without a line")

endmodule

### tb/reflectance_array_line_position_unit_tb.sv
`timescale 1ns / 100ps

module reflectance_array_line_position_unit_tb;

  localparam int SENSOR_N = 8;
  localparam int HALF     = SENSOR_N / 2;
  localparam int SETTLE   = 16;
  localparam int LIMIT    = 600000;

  // indexes with no register behind them
  localparam logic [rlp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rlp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [rlp_pkg::OFFSET_W-1:0] line_offset;
    logic                                line_found;
    logic                                all_black;
    logic                                all_white;
    logic [rlp_pkg::MAP_W-1:0]           black_map;
  } line_report_t;

  localparam line_report_t ALL_WHITE_REPORT = {4'd0, 1'b0, 1'b0, 1'b1, 8'h00};
  localparam line_report_t ALL_BLACK_REPORT = {4'd0, 1'b0, 1'b1, 1'b0, 8'hFF};

  typedef struct {
    bit                            is_cfg;
    logic [rlp_pkg::CFG_IDX_W-1:0] idx;
    logic [rlp_pkg::THR_W-1:0]     val;
    logic [rlp_pkg::PIN_W-1:0]     pins;
    bit                            first;
    bit                            last;
    bit                            typed;
    line_report_t                  want;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [rlp_pkg::PIN_W-1:0]       in_pin_levels;
  logic                            in_first;
  logic                            in_last;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rlp_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [rlp_pkg::THR_W-1:0]       cfg_data;
  logic                            out_valid;
  logic                            out_ready;
  logic signed [rlp_pkg::OFFSET_W-1:0] out_line_offset;
  logic                            out_line_found;
  logic                            out_all_black;
  logic                            out_all_white;
  logic [rlp_pkg::MAP_W-1:0]       out_black_map;

  // predictor state
  logic [rlp_pkg::COUNT_W-1:0] hits [SENSOR_N];
  rlp_pkg::cls_t               shade [SENSOR_N];
  logic [rlp_pkg::THR_W-1:0]   thr_lo;
  logic [rlp_pkg::THR_W-1:0]   thr_hi;

  line_report_t pending_reports[$];
  plan_row_t    plan[$];
  bit           calm;
  int           ticks;
  int           writes;
  int           reports;
  int           fails;

  always #10 clk = ~clk;

  reflectance_array_line_position_unit #(.SENSOR_COUNT(SENSOR_N)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pin_levels  (in_pin_levels),
    .in_first       (in_first),
    .in_last        (in_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_offset(out_line_offset),
    .out_line_found (out_line_found),
    .out_all_black  (out_all_black),
    .out_all_white  (out_all_white),
    .out_black_map  (out_black_map)
  );

  // Counts one tick; on a last tick classifies and builds the line report.
  function automatic bit advance_tick(input logic [rlp_pkg::PIN_W-1:0] pins, input bit first,
                                      input bit last, output line_report_t rep);
    int lsum, rsum, lcnt, rcnt, lavg, ravg, off;
    bit any_white, any_black;
    rep = '0;
    lsum = 0; rsum = 0; lcnt = 0; rcnt = 0;
    any_white = 1'b0; any_black = 1'b0;
    if (first)
      for (int i = 0; i < SENSOR_N; i++) hits[i] = '0;
    for (int i = 0; i < SENSOR_N; i++)
      if (pins[i] && hits[i] != rlp_pkg::COUNT_MAX) hits[i] = hits[i] + 1'b1;
    if (!last) return 1'b0;

    // white test wins when thresholds are crossed
    for (int i = 0; i < SENSOR_N; i++) begin
      if (hits[i] < thr_lo) begin
        shade[i] = rlp_pkg::CLS_WHITE;
      end else if (hits[i] > thr_hi) begin
        shade[i] = rlp_pkg::CLS_BLACK;
      end else if (shade[i] == rlp_pkg::CLS_UNKNOWN) begin
        if (i == 0) shade[i] = rlp_pkg::CLS_WHITE;
        else shade[i] = shade[i-1];
      end
    end

    for (int i = 0; i < SENSOR_N; i++) begin
      if (shade[i] == rlp_pkg::CLS_BLACK) begin
        any_black = 1'b1;
        rep.black_map[i] = 1'b1;
        if (i < HALF) begin
          lsum += HALF - i;
          lcnt++;
        end else begin
          rsum += i - HALF + 1;
          rcnt++;
        end
      end else if (shade[i] == rlp_pkg::CLS_WHITE) begin
        any_white = 1'b1;
      end
    end
    lavg = (lcnt != 0) ? lsum / lcnt : 0;
    ravg = (rcnt != 0) ? rsum / rcnt : 0;
    off = lavg - ravg;
    if (off > rlp_pkg::OFFSET_MAX) off = rlp_pkg::OFFSET_MAX;
    if (off < rlp_pkg::OFFSET_MIN) off = rlp_pkg::OFFSET_MIN;
    rep.line_found = !((lcnt == HALF && rcnt == SENSOR_N - HALF) || (lcnt == 0 && rcnt == 0));
    if (!rep.line_found) off = 0;
    rep.line_offset = off[rlp_pkg::OFFSET_W-1:0];
    rep.all_black = !any_white;
    rep.all_white = !any_black;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void cfg_row(input logic [rlp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rlp_pkg::THR_W-1:0] val);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endfunction

  function automatic void tick_row(input logic [rlp_pkg::PIN_W-1:0] pins, input bit first,
                                   input bit last, input bit typed, input line_report_t want);
    plan_row_t r;
    r = '{default: '0};
    r.pins = pins;
    r.first = first;
    r.last = last;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  task automatic send_tick(input logic [rlp_pkg::PIN_W-1:0] pins, input bit first,
                           input bit last, input bit typed, input line_report_t want);
    line_report_t rep;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_levels <= pins;
    in_first <= first;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    ticks++;
    if (advance_tick(pins, first, last, rep))
      pending_reports.push_back(typed ? want : rep);
  endtask

  // Thresholds only change with the block drained.
  task automatic write_reg(input logic [rlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlp_pkg::THR_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rlp_pkg::REG_THRESHOLD_LOW:  thr_lo = val;
      rlp_pkg::REG_THRESHOLD_HIGH: thr_hi = val;
      default: ;
    endcase
    writes++;
  endtask

  // One discharge window; each sensor gets its own chance of reading high.
  task automatic run_window(input int len, input int duty_lo, input int duty_hi);
    int duty [SENSOR_N];
    logic [rlp_pkg::PIN_W-1:0] pins;
    bit first;
    for (int i = 0; i < SENSOR_N; i++) duty[i] = $urandom_range(duty_lo, duty_hi);
    for (int t = 0; t < len; t++) begin
      for (int i = 0; i < SENSOR_N; i++) pins[i] = ($urandom_range(0, 99) < duty[i]);
      if (t == 0) first = ($urandom_range(0, 9) != 0);
      else first = (len <= 16 && $urandom_range(0, 29) == 0);
      send_tick(pins, first, t == len - 1, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int budget, input logic [rlp_pkg::THR_W-1:0] lo,
                           input logic [rlp_pkg::THR_W-1:0] hi,
                           input int min_len, input int max_len, input int duty_lo,
                           input int duty_hi);
    int start;
    if ($urandom_range(0, 1)) begin
      write_reg(rlp_pkg::REG_THRESHOLD_LOW, lo);
      write_reg(rlp_pkg::REG_THRESHOLD_HIGH, hi);
    end else begin
      write_reg(rlp_pkg::REG_THRESHOLD_HIGH, hi);
      write_reg(rlp_pkg::REG_THRESHOLD_LOW, lo);
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rlp_pkg::THR_W'($urandom));
    start = ticks;
    while (ticks - start < budget) begin
      // stray ticks outside a window
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3))
          send_tick(rlp_pkg::PIN_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
      run_window($urandom_range(min_len, max_len), duty_lo, duty_hi);
      if ($urandom_range(0, 19) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : check_reports
    line_report_t want;
    if (rst_n && out_valid && out_ready) begin
      reports++;
      if (pending_reports.size() == 0) begin
        $error("line report beat with nothing pending");
        fails++;
      end else begin
        want = pending_reports.pop_front();
        if (out_line_offset !== want.line_offset) begin
          $error("line_offset: expected %0d, got %0d", want.line_offset, out_line_offset);
          fails++;
        end
        if (out_line_found !== want.line_found) begin
          $error("line_found: expected %0b, got %0b", want.line_found, out_line_found);
          fails++;
        end
        if (out_all_black !== want.all_black) begin
          $error("all_black: expected %0b, got %0b", want.all_black, out_all_black);
          fails++;
        end
        if (out_all_white !== want.all_white) begin
          $error("all_white: expected %0b, got %0b", want.all_white, out_all_white);
          fails++;
        end
        if (out_black_map !== want.black_map) begin
          $error("black_map: expected %02h, got %02h", want.black_map, out_black_map);
          fails++;
        end
      end
    end
  end

  // receiver back-pressure: mostly short stalls, now and then long ones or long open runs
  initial begin : drive_ready
    int r;
    out_ready <= 1'b1;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 80) repeat ($urandom_range(1, 6)) @(posedge clk);
      else repeat ($urandom_range(30, 200)) @(posedge clk);
      out_ready <= 1'b0;
      r = $urandom_range(0, 99);
      if (r < 70) repeat ($urandom_range(1, 3)) @(posedge clk);
      else if (r < 95) repeat ($urandom_range(4, 10)) @(posedge clk);
      else repeat ($urandom_range(20, 40)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $error("timed out with %0d reports pending", pending_reports.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [rlp_pkg::THR_W-1:0] lo, hi, t;
    in_valid <= 1'b0;
    in_pin_levels <= '0;
    in_first <= 1'b0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= rlp_pkg::REG_THRESHOLD_LOW;
    cfg_data <= '0;
    rst_n <= 1'b0;
    calm = 1'b0;
    thr_lo = rlp_pkg::THR_LOW_RST;
    thr_hi = rlp_pkg::THR_HIGH_RST;
    for (int i = 0; i < SENSOR_N; i++) begin
      hits[i] = '0;
      shade[i] = rlp_pkg::CLS_UNKNOWN;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cfg_row(rlp_pkg::REG_THRESHOLD_LOW, 8'd1);
    cfg_row(rlp_pkg::REG_THRESHOLD_HIGH, 8'd1);
    // counts of 1 sit in the band while every class is still unknown
    tick_row(8'h65, 1'b1, 1'b0, 1'b0, '0);
    tick_row(8'hCE, 1'b0, 1'b1, 1'b0, '0);
    tick_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
    tick_row(8'h00, 1'b1, 1'b1, 1'b1, ALL_WHITE_REPORT);
    tick_row(8'h01, 1'b1, 1'b0, 1'b0, '0);
    tick_row(8'h01, 1'b0, 1'b1, 1'b0, '0);
    tick_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
    tick_row(8'h80, 1'b0, 1'b1, 1'b0, '0);
    tick_row(8'h18, 1'b0, 1'b0, 1'b0, '0);
    tick_row(8'h3C, 1'b1, 1'b0, 1'b0, '0);
    tick_row(8'h3C, 1'b0, 1'b1, 1'b0, '0);
    tick_row(8'h42, 1'b0, 1'b1, 1'b0, '0);
    cfg_row(REG_SPARE_A, 8'hAA);
    cfg_row(REG_SPARE_B, 8'h55);
    cfg_row(rlp_pkg::REG_THRESHOLD_LOW, 8'd0);
    cfg_row(rlp_pkg::REG_THRESHOLD_HIGH, 8'd0);
    tick_row(8'hFF, 1'b1, 1'b1, 1'b1, ALL_BLACK_REPORT);
    tick_row(8'h00, 1'b1, 1'b1, 1'b1, ALL_BLACK_REPORT);
    cfg_row(rlp_pkg::REG_THRESHOLD_LOW, 8'd5);
    cfg_row(rlp_pkg::REG_THRESHOLD_HIGH, 8'd2);
    tick_row(8'hF0, 1'b1, 1'b0, 1'b0, '0);
    tick_row(8'h0F, 1'b0, 1'b0, 1'b0, '0);
    tick_row(8'h33, 1'b0, 1'b0, 1'b0, '0);
    tick_row(8'hF5, 1'b0, 1'b0, 1'b0, '0);
    tick_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    tick_row(8'hC3, 1'b0, 1'b1, 1'b0, '0);
    cfg_row(rlp_pkg::REG_THRESHOLD_LOW, 8'd255);
    cfg_row(rlp_pkg::REG_THRESHOLD_HIGH, 8'd255);
    tick_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].val);
      else send_tick(plan[k].pins, plan[k].first, plan[k].last, plan[k].typed, plan[k].want);
    end

    run_phase(90, 8'd0, 8'd0, 1, 6, 0, 100);
    run_phase(90, 8'd255, 8'd255, 1, 6, 0, 100);
    run_phase(90, 8'd0, 8'd255, 1, 6, 0, 100);
    repeat (7) begin
      lo = rlp_pkg::THR_W'($urandom_range(0, 12));
      hi = lo + rlp_pkg::THR_W'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) begin
        t = lo; lo = hi; hi = t;
      end
      calm = ($urandom_range(0, 3) == 0);
      run_phase(90, lo, hi, 1, 12, 0, 100);
    end
    calm = 1'b0;
    // full-length windows around the default band
    run_phase(380, rlp_pkg::THR_LOW_RST, rlp_pkg::THR_HIGH_RST, 190, 210, 40, 60);
    // long windows that push counts into saturation
    run_phase(280, 8'd255, 8'd0, 280, 320, 75, 100);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d ticks across short, full-length and saturating windows", ticks);
    $display("Checked %0d line reports over %0d register writes", reports, writes);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
